[hw/rtl/ptt_pkg.sv]
package ptt_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int MAX_RUN      = 16;
  localparam int TIME_W       = 48;
  localparam int PER_W        = 32;
  localparam int SLOT_FIELD_W = 4;
  localparam int RUN_CNT_W    = $clog2(MAX_RUN + 1);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] first_due;
    logic [PER_W-1:0]  period;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] fired_slot;
    logic                    last_of_run;
    logic                    add_dropped;
  } out_item_t;

  typedef struct packed {
    logic add_we;
    logic tick_ld;
    logic rd_en;
    logic fire_we;
  } ptt_cmd_t;

  typedef struct packed {
    logic hit;
    logic full;
  } ptt_stat_t;

endpackage

[hw/rtl/ptt_datapath.sv]
module ptt_datapath
  import ptt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptt_cmd_t         cmd_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  input  logic [IDX_W-1:0] cmp_idx_i,
  input  in_item_t         in_item_i,
  output ptt_stat_t        stat_o
);

  logic [SLOTS-1:0]  valid_q;
  logic [TIME_W-1:0] due_mem [SLOTS];
  logic [PER_W-1:0]  per_mem [SLOTS];
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] due_rd_q;
  logic [PER_W-1:0]  per_rd_q;

  logic [IDX_W-1:0]  free_idx;
  logic              full;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] resched;
  logic              due_we;
  logic [IDX_W-1:0]  due_wa;
  logic [TIME_W-1:0] due_wd;

  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
        full     = 1'b0;
      end
    end
  end

  assign sum     = {1'b0, now_q} + {{(TIME_W + 1 - PER_W){1'b0}}, per_rd_q};
  assign resched = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

  assign due_we = cmd_i.add_we || (cmd_i.fire_we && (per_rd_q != '0));
  assign due_wa = cmd_i.add_we ? free_idx : cmp_idx_i;
  assign due_wd = cmd_i.add_we ? in_item_i.first_due : resched;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      now_q   <= '0;
    end else begin
      if (cmd_i.add_we) begin
        valid_q[free_idx] <= 1'b1;
      end else if (cmd_i.fire_we && (per_rd_q == '0)) begin
        valid_q[cmp_idx_i] <= 1'b0;
      end
      if (cmd_i.tick_ld) begin
        now_q <= in_item_i.now_time;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (due_we) begin
      due_mem[due_wa] <= due_wd;
    end
    if (cmd_i.add_we) begin
      per_mem[free_idx] <= in_item_i.period;
    end
    if (cmd_i.rd_en) begin
      due_rd_q <= due_mem[rd_idx_i];
      per_rd_q <= per_mem[rd_idx_i];
    end
  end

  assign stat_o.hit  = valid_q[cmp_idx_i] && (due_rd_q <= now_q);
  assign stat_o.full = full;

endmodule

[hw/rtl/ptt_ctrl.sv]
module ptt_ctrl
  import ptt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             in_op_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  ptt_stat_t        stat_i,
  output ptt_cmd_t         cmd_o,
  output logic [IDX_W-1:0] rd_idx_o,
  output logic [IDX_W-1:0] cmp_idx_o
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_DROP  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                 pend_v_q, pend_v_d;
  logic [IDX_W-1:0]     pend_slot_q, pend_slot_d;
  logic [RUN_CNT_W-1:0] fire_cnt_q, fire_cnt_d;
  logic                 out_v_q, out_v_d;
  out_item_t            out_q;

  logic                 accept;
  logic                 out_free;
  logic                 can_fire;
  logic                 out_ld;
  logic                 out_last;
  logic                 out_drop;
  logic [IDX_W-1:0]     out_slot;
  logic [IDX_W+SLOT_FIELD_W-1:0] slot_ext;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_v_q || !out_stall_i;
  assign can_fire   = stat_i.hit && (fire_cnt_q < RUN_CNT_W'(MAX_RUN));
  assign rd_idx_o   = rd_cnt_q[IDX_W-1:0];
  assign cmp_idx_o  = cmp_idx_q;

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_idx_d   = cmp_idx_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    fire_cnt_d  = fire_cnt_q;
    cmd_o       = '0;
    out_ld      = 1'b0;
    out_last    = 1'b0;
    out_drop    = 1'b0;
    out_slot    = pend_slot_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_op_i == OP_TICK) begin
            cmd_o.tick_ld = 1'b1;
            cmd_o.rd_en   = 1'b1;
            rd_cnt_d      = CNT_W'(1);
            cmp_idx_d     = '0;
            pend_v_d      = 1'b0;
            fire_cnt_d    = '0;
            state_d       = S_SCAN;
          end else if (stat_i.full) begin
            state_d = S_DROP;
          end else begin
            cmd_o.add_we = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (!(can_fire && pend_v_q && !out_free)) begin
          if (can_fire) begin
            cmd_o.fire_we = 1'b1;
            fire_cnt_d    = fire_cnt_q + 1'b1;
            pend_v_d      = 1'b1;
            pend_slot_d   = cmp_idx_q;
            out_ld        = pend_v_q;
          end
          if (rd_cnt_q < CNT_W'(SLOTS)) begin
            cmd_o.rd_en = 1'b1;
            cmp_idx_d   = rd_cnt_q[IDX_W-1:0];
            rd_cnt_d    = rd_cnt_q + 1'b1;
          end else begin
            rd_cnt_d = '0;
            state_d  = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_ld   = 1'b1;
          out_last = 1'b1;
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      S_DROP: begin
        if (out_free) begin
          out_ld   = 1'b1;
          out_last = 1'b1;
          out_drop = 1'b1;
          out_slot = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign slot_ext = {{SLOT_FIELD_W{1'b0}}, out_slot};

  always_comb begin
    out_v_d = out_v_q;
    if (out_ld) begin
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_cnt_q   <= '0;
      cmp_idx_q  <= '0;
      pend_v_q   <= 1'b0;
      fire_cnt_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      cmp_idx_q  <= cmp_idx_d;
      pend_v_q   <= pend_v_d;
      fire_cnt_q <= fire_cnt_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    if (out_ld) begin
      out_q.fired_slot  <= slot_ext[SLOT_FIELD_W-1:0];
      out_q.last_of_run <= out_last;
      out_q.add_dropped <= out_drop;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

[hw/rtl/periodic_timer_table_core.sv]
// Channel  Dir  Handshake               Payload
// in       in   in_valid_i/in_stall_o   in_item_i  (op, now_time, first_due, period)
// out      out  out_valid_o/out_stall_i out_item_o (fired_slot, last_of_run, add_dropped)
//
// Add: written straight into a free slot; a full table instead issues a drop transaction,
//   which the out channel can hold back by stalling it.
// Tick: one slot per cycle through the registered table read port, except while a stalled
//   out channel holds back a fired slot.
// The last fired slot of a tick is held back until the scan ends, to carry last_of_run.
// Reset clears all slot valid flops and the latest time at once; no clearing pass.
// in_stall_o is high for the whole tick scan, the drop state and the final flush.
module periodic_timer_table_core
  import ptt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ptt_cmd_t         cmd;
  ptt_stat_t        stat;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] cmp_idx;

  ptt_ctrl #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_op_i     (in_item_i.op),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .rd_idx_o    (rd_idx),
    .cmp_idx_o   (cmp_idx)
  );

  ptt_datapath #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_idx_i  (rd_idx),
    .cmp_idx_i (cmp_idx),
    .in_item_i (in_item_i),
    .stat_o    (stat)
  );

endmodule

[hw/rtl/ptt_checker.sv]
module ptt_checker
  import ptt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled out transaction changed");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_item_i.op == OP_TICK) |=> in_stall_o)
    else $error("tick transaction did not start a scan");

  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("out transaction appeared without pending work");

  a_drop_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.add_dropped |->
      out_item_o.last_of_run && (out_item_o.fired_slot == '0))
    else $error("drop transaction carries bad fields");

endmodule

bind periodic_timer_table_core ptt_checker u_ptt_checker (.*);
